FILE: rtl/assembler_number_literal_parser_top_defines.svh
// Assertion macros shared by the number literal parser RTL.
`ifndef ASSEMBLER_NUMBER_LITERAL_PARSER_TOP_DEFINES_SVH
`define ASSEMBLER_NUMBER_LITERAL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ANLP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("number literal parser assertion failed");

// Next-cycle implication, checked outside reset.
`define ANLP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("number literal parser assertion failed");

`endif

FILE: rtl/anlp_pkg.sv
// Package: types, character codes and helper functions of the number literal parser.
package anlp_pkg;

   localparam int CH_W             = 8;
   localparam int WORD_W           = 16;
   localparam int DIGIT_W          = 4;
   localparam int MAX_TOKEN_CHARS_DEFAULT = 100;

   // ASCII codes the parser looks for.
   localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CH_W-1:0] CH_UPPER_H = 8'h48;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CH_W-1:0] CH_LOWER_H = 8'h68;

   // One character of a token.
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last_char;
   } anlp_char_type;

   // One parsed result.
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              is_number;
   } anlp_result_type;

   // Classification of a character as a hex digit.
   typedef struct packed {
      logic               ok;
      logic [DIGIT_W-1:0] val;
   } anlp_digit_type;

   function automatic anlp_digit_type anlp_hex_digit(input logic [CH_W-1:0] c);
      anlp_digit_type d;
      logic [CH_W-1:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff  = c - CH_ZERO;
         d.ok  = 1'b1;
         d.val = diff[DIGIT_W-1:0];
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         diff  = c - CH_LOWER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[DIGIT_W-1:0];
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         diff  = c - CH_UPPER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[DIGIT_W-1:0];
      end
      return d;
   endfunction

endpackage

FILE: rtl/anlp_channels.sv
// Valid/ready channel interfaces for characters in and parsed words out.
interface anlp_req_if
   import anlp_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            last_char;

   modport source (output valid, output ch, output last_char, input ready);
   modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface anlp_rsp_if
   import anlp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;
   logic              is_number;

   modport source (output valid, output value, output is_number, input ready);
   modport sink   (input valid, input value, input is_number, output ready);
endinterface

FILE: rtl/anlp_accum.sv
// Token state: decimal and hex accumulators, sign, validity and character count.
`include "assembler_number_literal_parser_top_defines.svh"

module anlp_accum
   import anlp_pkg::*;
#(
   parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  anlp_char_type   char_in,
   output anlp_result_type result
);

   localparam int CNT_W = $clog2(MAX_TOKEN_CHARS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_CHARS);

   logic [WORD_W-1:0] dec_ff, dec_in;
   logic [WORD_W-1:0] hex_ff, hex_in;
   logic              neg_ff, neg_in;
   logic              decv_ff, decv_in;
   logic              hexv_ff, hexv_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   anlp_digit_type    hd;
   logic [WORD_W-1:0] word;
   logic              ok;
   logic              is_digit;
   logic              is_h;

   // Fold the current character into the token state.
   always_comb begin
      hd       = anlp_hex_digit(char_in.ch);
      is_digit = (char_in.ch >= CH_ZERO) && (char_in.ch <= CH_NINE);
      is_h     = (char_in.ch == CH_LOWER_H) || (char_in.ch == CH_UPPER_H);
      dec_in   = dec_ff;
      hex_in   = hex_ff;
      neg_in   = neg_ff;
      decv_in  = decv_ff;
      hexv_in  = hexv_ff;
      pend_in  = pend_ff;
      cnt_in   = cnt_ff;
      if (cnt_ff < CNT_MAX) begin
         if (char_in.ch == CH_NUL) begin
            cnt_in = CNT_MAX;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0 && char_in.ch == CH_MINUS) begin
               neg_in = 1'b1;
            end else begin
               // Decimal path: multiply by ten as two shifts and an add.
               if (is_digit) begin
                  dec_in = (dec_ff << 3) + (dec_ff << 1) + WORD_W'(hd.val);
               end else begin
                  decv_in = 1'b0;
               end
               // Hex path: a suffix seen earlier was not the last character.
               if (pend_ff) begin
                  hexv_in = 1'b0;
               end
               pend_in = is_h;
               if (!is_h) begin
                  if (hd.ok) begin
                     hex_in = {hex_ff[WORD_W-DIGIT_W-1:0], hd.val};
                  end else begin
                     hexv_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Pick the path by the suffix and apply the sign.
   always_comb begin
      word = pend_in ? hex_in : dec_in;
      ok   = pend_in ? hexv_in : decv_in;
      result.is_number = ok;
      if (!ok) begin
         result.value = '0;
      end else if (neg_in) begin
         result.value = '0 - word;
      end else begin
         result.value = word;
      end
   end

   // State registers; reset and the final character of a token clear them.
   always_ff @(posedge clock) begin
      if (reset || (take && char_in.last_char)) begin
         dec_ff  <= '0;
         hex_ff  <= '0;
         neg_ff  <= 1'b0;
         decv_ff <= 1'b1;
         hexv_ff <= 1'b1;
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (take) begin
         dec_ff  <= dec_in;
         hex_ff  <= hex_in;
         neg_ff  <= neg_in;
         decv_ff <= decv_in;
         hexv_ff <= hexv_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   // The count saturates at the token limit, a sign is only taken as the first character,
   // and a token end starts afresh.
   `ANLP_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_MAX)
   `ANLP_ASSERT_IMP(a_neg_first, clock, reset, neg_ff, cnt_ff != '0)
   `ANLP_ASSERT_NXT(a_token_clear, clock, reset, take && char_in.last_char, cnt_ff == '0 && decv_ff && hexv_ff && !pend_ff && !neg_ff)

endmodule

FILE: rtl/assembler_number_literal_parser_top.sv
// Top level of the number literal parser: input register, token state and result register.
// A final character passes the input register; its result then loads the result register.
// Throughput: one character per cycle; the result register may hold while characters flow.
// A stalled result stops only the final character of the next token in the input register.
// Reset (synchronous, active high) empties both registers and clears the token state.
`include "assembler_number_literal_parser_top_defines.svh"

module assembler_number_literal_parser_top
   import anlp_pkg::*;
#(
   parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   anlp_req_if.sink   req_chan,
   anlp_rsp_if.source rsp_chan
);

   logic            s1_valid_ff, s1_valid_in;
   anlp_char_type   s1_char_ff;
   logic            s1_take;
   logic            req_accept;

   logic            rsp_valid_ff, rsp_valid_in;
   anlp_result_type rsp_data_ff;
   anlp_result_type result;

   // The registered character moves on unless it ends a token and the result is still held.
   assign s1_take = s1_valid_ff &&
                    (!s1_char_ff.last_char || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_take;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_accept || (s1_valid_ff && !s1_take);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff.ch        <= req_chan.ch;
         s1_char_ff.last_char <= req_chan.last_char;
      end
   end

   anlp_accum #(
      .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .take   (s1_take),
      .char_in(s1_char_ff),
      .result (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_take && s1_char_ff.last_char) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && s1_char_ff.last_char) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_data_ff.value;
   assign rsp_chan.is_number = rsp_data_ff.is_number;

   // An invalid token carries a zero word, a held character stays, a result is never overwritten.
   `ANLP_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.is_number, rsp_data_ff.value == '0)
   `ANLP_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_take, s1_valid_ff && $stable(s1_char_ff))
   `ANLP_ASSERT_IMP(a_no_overwrite, clock, reset, s1_take && s1_char_ff.last_char && rsp_valid_ff, rsp_chan.ready)

endmodule
